[hdl/lpr_pkg.sv]
// ----------------------------------------------------------------------------
// LRU page replacer package
// Fixed field widths, reset values and the control bundle that the top level
// hands to the recency update logic.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int FAULT_W = 32;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX         = '1;

  // What a reference does to the frame set.
  typedef struct packed {
    logic hit;    // page already resident
    logic fill;   // miss that takes the next free frame
    logic evict;  // miss that replaces the least recently used frame
  } lpr_ctl_t;

endpackage

[hdl/lpr_match.sv]
// ----------------------------------------------------------------------------
// LRU page replacer tag match
// Compares the referenced page with every filled frame in parallel and
// returns the lowest matching frame index.
// ----------------------------------------------------------------------------
module lpr_match #(
  parameter int FRAMES     = 16,
  parameter int PAGE_WIDTH = 16,
  parameter int IW         = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int CW         = $clog2(FRAMES + 1)
) (
  input  logic [PAGE_WIDTH-1:0] page,
  input  logic [PAGE_WIDTH-1:0] frame_page [FRAMES],
  input  logic [CW-1:0]         filled_eff,
  output logic                  hit,
  output logic [IW-1:0]         hit_idx
);

  // Walking downward leaves the lowest matching frame in hit_idx.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if ((CW'(i) < filled_eff) && (frame_page[i] == page)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

endmodule

[hdl/lpr_recency.sv]
// ----------------------------------------------------------------------------
// LRU page replacer recency update
// Picks the frame a reference lands in and computes the next recency ranks
// and fill count. Rank 0 is the most recently used frame.
// ----------------------------------------------------------------------------
module lpr_recency
  import lpr_pkg::*;
#(
  parameter int FRAMES = 16,
  parameter int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int CW     = $clog2(FRAMES + 1)
) (
  input  lpr_ctl_t      ctl,
  input  logic [IW-1:0] hit_idx,
  input  logic [CW-1:0] filled_eff,
  input  logic [IW-1:0] rank [FRAMES],
  output logic [IW-1:0] slot_idx,
  output logic [IW-1:0] rank_next [FRAMES],
  output logic [CW-1:0] filled_next
);

  logic [IW-1:0] victim;
  logic [CW-1:0] thr;
  logic [CW-1:0] limit;

  // With all frames filled the ranks form a permutation, so the oldest frame
  // is the one whose rank equals the fill count minus one.
  always_comb begin
    victim = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if ((CW'(i) < filled_eff) && (CW'(rank[i]) == filled_eff - CW'(1))) begin
        victim = IW'(i);
      end
    end
  end

  always_comb begin
    filled_next = filled_eff;
    if (ctl.hit) begin
      slot_idx = hit_idx;
      thr      = CW'(rank[hit_idx]);
      limit    = filled_eff;
    end else if (ctl.fill) begin
      // A new frame starts older than all others, so every filled frame ages.
      slot_idx    = IW'(filled_eff);
      thr         = filled_eff;
      limit       = filled_eff + CW'(1);
      filled_next = filled_eff + CW'(1);
    end else begin
      slot_idx = victim;
      thr      = CW'(rank[victim]);
      limit    = filled_eff;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_next[i] = rank[i];
      if (CW'(i) < limit) begin
        if (IW'(i) == slot_idx) begin
          rank_next[i] = '0;
        end else if (CW'(rank[i]) < thr) begin
          rank_next[i] = rank[i] + IW'(1);
        end
      end
    end
  end

endmodule

[hdl/lru_page_replacer_unit.sv]
// ----------------------------------------------------------------------------
// LRU page replacer
// Fully associative least-recently-used page replacement with a saturating
// fault counter.
// ----------------------------------------------------------------------------
// Each input beat is one page reference and yields one result beat. The
// block takes one reference per clock cycle while results are taken: a
// reference is captured in an input register, and once the result
// register is free or being taken, a parallel tag compare against all
// frames plus the recency rank update settle the frame state and load the
// result register. While a result waits to be taken, one more reference
// can still enter the input register; after that the input stalls until
// the waiting result beat is taken. Writing frame_count empties all
// frames but keeps the fault count; values of 0 act as 1 and values above
// FRAMES act as FRAMES. Write it only while no reference is in flight.
module lru_page_replacer_unit
  import lpr_pkg::*;
#(
  parameter int FRAMES     = 16,
  parameter int PAGE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAGE_WIDTH-1:0] page,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [SLOT_W-1:0]     slot,
  output logic                  evicted_valid,
  output logic [PAGE_WIDTH-1:0] evicted_page,
  output logic [FAULT_W-1:0]    fault_total,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]      frame_count;
  logic                  s1_valid;
  logic [PAGE_WIDTH-1:0] s1_page;
  logic [PAGE_WIDTH-1:0] frame_page [FRAMES];
  logic [CW-1:0]         filled;
  logic [IW-1:0]         rank [FRAMES];
  logic [FAULT_W-1:0]    fault_count;

  logic [CW-1:0]         active_n;
  logic [CW-1:0]         filled_eff;
  logic                  m_hit;
  logic [IW-1:0]         hit_idx;
  lpr_ctl_t              ctl;
  logic [IW-1:0]         slot_idx;
  logic [IW-1:0]         rank_next [FRAMES];
  logic [CW-1:0]         filled_next;
  logic [FAULT_W-1:0]    fault_next;
  logic                  advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    if (frame_count == '0) begin
      active_n = CW'(1);
    end else if (int'(frame_count) > FRAMES) begin
      active_n = CW'(FRAMES);
    end else begin
      active_n = CW'(frame_count);
    end
    filled_eff = (filled > active_n) ? active_n : filled;
  end

  lpr_match #(
    .FRAMES     (FRAMES),
    .PAGE_WIDTH (PAGE_WIDTH),
    .IW         (IW),
    .CW         (CW)
  ) u_match (
    .page       (s1_page),
    .frame_page (frame_page),
    .filled_eff (filled_eff),
    .hit        (m_hit),
    .hit_idx    (hit_idx)
  );

  always_comb begin
    ctl.hit   = m_hit;
    ctl.fill  = !m_hit && (filled_eff != active_n);
    ctl.evict = !m_hit && (filled_eff == active_n);
  end

  lpr_recency #(
    .FRAMES (FRAMES),
    .IW     (IW),
    .CW     (CW)
  ) u_recency (
    .ctl         (ctl),
    .hit_idx     (hit_idx),
    .filled_eff  (filled_eff),
    .rank        (rank),
    .slot_idx    (slot_idx),
    .rank_next   (rank_next),
    .filled_next (filled_next)
  );

  assign fault_next = (!m_hit && (fault_count != FAULT_MAX)) ?
                      fault_count + FAULT_W'(1) : fault_count;

  // Control state and the frame bookkeeping that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      filled      <= '0;
      fault_count <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        frame_count <= cfg_wdata;
        filled      <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank[i] <= '0;
        end
      end else if (advance) begin
        filled      <= filled_next;
        fault_count <= fault_next;
        for (int i = 0; i < FRAMES; i++) begin
          rank[i] <= rank_next[i];
        end
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: the input register, the page tags and the result register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_page <= page;
    end
    if (advance) begin
      hit           <= m_hit;
      slot          <= SLOT_W'(slot_idx);
      evicted_valid <= ctl.evict;
      evicted_page  <= ctl.evict ? frame_page[slot_idx] : '0;
      fault_total   <= fault_next;
      if (!m_hit) begin
        frame_page[slot_idx] <= s1_page;
      end
    end
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// LRU page replacer testbench
// Streams page references through the replacer and checks every result beat
// against a local model of the frame table and recency ranks. The run steps
// through several frame counts, out-of-range settings among them, with random
// gaps on both sides, one long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
  import lpr_pkg::*;

  localparam int PAGE_W      = 16;
  localparam int FRAME_N     = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } outcome_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [PAGE_W-1:0]  page          = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;
  logic               cfg_we        = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata     = '0;

  lru_page_replacer_unit #(
    .FRAMES     (FRAME_N),
    .PAGE_WIDTH (PAGE_W)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [PAGE_W-1:0] pending_refs [$];
  outcome_t          awaited_outcomes [$];
  int unsigned       idle_pct      = 0;
  int unsigned       hold_requests = 0;
  int unsigned       errors        = 0;

  // Local copy of the frame table, recency ranks and fault counter.
  logic [PAGE_W-1:0]  frame_pg [FRAME_N];
  int unsigned        frame_rank [FRAME_N];
  int unsigned        filled_frames = 0;
  logic [FAULT_W-1:0] fault_count   = '0;
  logic [CFG_W-1:0]   frame_setting = FRAME_COUNT_RESET;

  function automatic int unsigned active_frames(logic [CFG_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > FRAME_N) return FRAME_N;
    return setting;
  endfunction

  function automatic void empty_frames();
    filled_frames = 0;
    foreach (frame_rank[i]) frame_rank[i] = 0;
  endfunction

  // Frame s becomes the most recent; every filled frame younger than it ages.
  function automatic void make_recent(int unsigned s, int unsigned old_rank);
    for (int unsigned i = 0; i < filled_frames; i++) begin
      if (i != s && frame_rank[i] < old_rank) frame_rank[i]++;
    end
    frame_rank[s] = 0;
  endfunction

  function automatic outcome_t lru_lookup(logic [PAGE_W-1:0] pg);
    outcome_t    r;
    int unsigned n;
    int unsigned oldest;
    bit          found;
    r     = '0;
    found = 1'b0;
    n     = active_frames(frame_setting);
    if (filled_frames > n) filled_frames = n;
    for (int unsigned i = 0; i < filled_frames && !found; i++) begin
      if (frame_pg[i] == pg) begin
        found  = 1'b1;
        r.slot = SLOT_W'(i);
      end
    end
    r.hit = found;
    if (found) begin
      make_recent(r.slot, frame_rank[r.slot]);
    end else begin
      if (fault_count != FAULT_MAX) fault_count++;
      if (filled_frames < n) begin
        r.slot = SLOT_W'(filled_frames);
        filled_frames++;
        frame_pg[r.slot] = pg;
        make_recent(r.slot, filled_frames - 1);
      end else begin
        oldest = 0;
        for (int unsigned i = 0; i < filled_frames; i++) begin
          if (frame_rank[i] >= oldest) begin
            oldest = frame_rank[i];
            r.slot = SLOT_W'(i);
          end
        end
        r.ev_valid       = 1'b1;
        r.ev_page        = frame_pg[r.slot];
        frame_pg[r.slot] = pg;
        make_recent(r.slot, frame_rank[r.slot]);
      end
    end
    r.faults = fault_count;
    return r;
  endfunction

  // A gap comes with a chance of idle_pct percent; it is usually short and now and then long.
  function automatic int unsigned idle_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 8);
    return $urandom_range(3, 1);
  endfunction

  // Page reference driver.
  int unsigned send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) awaited_outcomes.push_back(lru_lookup(page));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_refs.size() != 0) begin
          page     <= pending_refs.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  int unsigned ready_hold  = 0;
  int unsigned hold_served = 0;

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result beat with no page reference outstanding");
          errors++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errors++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, slot);
            errors++;
          end
          if (evicted_valid !== want.ev_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.ev_valid, evicted_valid);
            errors++;
          end
          if (evicted_page !== want.ev_page) begin
            $error("evicted_page: expected %h, got %h", want.ev_page, evicted_page);
            errors++;
          end
          if (fault_total !== want.faults) begin
            $error("fault_total: expected %0d, got %0d", want.faults, fault_total);
            errors++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        ready_hold  = HOLD_CYCLES;
      end
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        ready_hold = idle_gap();
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_refs.size() != 0 || in_valid || awaited_outcomes.size() != 0);
  endtask

  task automatic write_frame_count(logic [CFG_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    frame_setting = value;
    empty_frames();
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A working set as large as the frame table or a little larger gives a mix
  // of hits, fills and evictions; one reference in ten is an arbitrary page.
  task automatic queue_refs(int unsigned count, int unsigned pool_n);
    logic [PAGE_W-1:0] pool [$];
    repeat (pool_n) pool.push_back(PAGE_W'($urandom));
    repeat (count) begin
      if ($urandom_range(9) == 0) pending_refs.push_back(PAGE_W'($urandom));
      else pending_refs.push_back(pool[$urandom_range(pool_n - 1)]);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings [11];
    int unsigned      n;
    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd4, 5'd9, 5'd15, 5'd16, 5'd5};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset frame count: extreme pages, hits on both, alternating bit patterns.
    pending_refs = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                     16'h8000, 16'h0001};
    // Two frames: hits refresh recency, so the eviction victim changes.
    write_frame_count(5'd2);
    pending_refs = '{16'd5, 16'd9, 16'd5, 16'd7, 16'd9, 16'd5};
    // Zero behaves as a single frame.
    write_frame_count(5'd0);
    pending_refs = '{16'd3, 16'd3, 16'd4, 16'd3};

    foreach (settings[ph]) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 25 : 60;
      write_frame_count(settings[ph]);
      n = active_frames(settings[ph]);
      queue_refs(70, n + $urandom_range(n / 2 + 2));
      // Sender pause until every result is back, then keep going.
      wait_drained();
      if (ph == 3) hold_requests++;
      queue_refs(70, n + $urandom_range(n / 2 + 2));
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[lru_page_replacer_unit.f]
hdl/lpr_pkg.sv
hdl/lpr_match.sv
hdl/lpr_recency.sv
hdl/lru_page_replacer_unit.sv
verif/testbench.sv
